/* hw/rtl/bucket_hash_insert_defines.svh */
// Assertion macros for the bucket hash insert block.
// Taken in by the top level; no other dependencies.
`ifndef BUCKET_HASH_INSERT_DEFINES_SVH
`define BUCKET_HASH_INSERT_DEFINES_SVH

// check the consequent in the same cycle as the antecedent
`define BHI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check the consequent in the cycle after the antecedent
`define BHI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/bhi_pkg.sv */
// Package for the bucket hash insert block: field widths, codes, state and
// controller/datapath command and status types. No dependencies.
`default_nettype none

package bhi_pkg;

   localparam int KEY_W             = 31;
   localparam int ROW_FIELD_W       = 4;
   localparam int SLOT_FIELD_W      = 2;
   localparam int STATUS_W          = 2;
   localparam int DEF_ROW_COUNT     = 11;
   localparam int DEF_SLOTS_PER_ROW = 3;

   localparam int HASH_DIGIT_W = 4;
   localparam int HASH_STEPS   = (KEY_W + HASH_DIGIT_W - 1) / HASH_DIGIT_W;
   localparam int HASH_CNT_W   = $clog2(HASH_STEPS);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INSERTED,
      STATUS_FULL,
      STATUS_ZERO,
      STATUS_READ
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ_RD,
      S_READ_CHK,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic capture;
      logic set_zero;
      logic read_rd;
      logic read_cap;
      logic hash_step;
      logic probe_start;
      logic probe_rd;
      logic probe_next;
      logic probe_write;
      logic set_full;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic in_read;
      logic in_zero;
      logic hash_last;
      logic found;
      logic probe_last;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

/* hw/rtl/bhi_req_if.sv */
// Request channel interface: valid/ready handshake and the request fields.
// Depends on bhi_pkg.
`default_nettype none

interface bhi_req_if
   import bhi_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [KEY_W-1:0]        key;
   logic [ROW_FIELD_W-1:0]  read_row;
   logic [SLOT_FIELD_W-1:0] read_slot;

   modport source (output valid, command, key, read_row, read_slot, input ready);
   modport sink (input valid, command, key, read_row, read_slot, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bhi_rsp_if.sv */
// Response channel interface: valid/ready handshake and the result fields.
// Depends on bhi_pkg.
`default_nettype none

interface bhi_rsp_if
   import bhi_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic [ROW_FIELD_W-1:0]  placed_row;
   logic [SLOT_FIELD_W-1:0] placed_slot;
   logic [KEY_W-1:0]        read_value;

   modport source (output valid, status, placed_row, placed_slot, read_value, input ready);
   modport sink (input valid, status, placed_row, placed_slot, read_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bhi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bhi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/bhi_ctrl.sv */
// Controller state machine for the bucket hash insert block.
// Depends on bhi_pkg; drives commands to bhi_dp and reads its status.
`default_nettype none

module bhi_ctrl
   import bhi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_ready,
   input  wire dp_sts_type   sts,
   output      ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (sts.in_read) begin
                  state_in = S_READ_RD;
               end else if (sts.in_zero) begin
                  cmd.set_zero = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_READ_RD: begin
            cmd.read_rd = 1'b1;
            state_in    = S_READ_CHK;
         end
         S_READ_CHK: begin
            cmd.read_cap = 1'b1;
            state_in     = S_DONE;
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               cmd.probe_start = 1'b1;
               state_in        = S_PROBE_RD;
            end
         end
         S_PROBE_RD: begin
            cmd.probe_rd = 1'b1;
            state_in     = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            if (sts.found) begin
               cmd.probe_write = 1'b1;
               state_in        = S_DONE;
            end else if (sts.probe_last) begin
               cmd.set_full = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_PROBE_RD;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/bhi_dp.sv */
// Datapath for the bucket hash insert block: row RAM, hash unit, probe
// counters and result registers. Depends on bhi_pkg and bhi_ram.
`default_nettype none

module bhi_dp
   import bhi_pkg::*;
#(
   parameter int ROW_COUNT     = DEF_ROW_COUNT,
   parameter int SLOTS_PER_ROW = DEF_SLOTS_PER_ROW
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ctrl_cmd_type            cmd,
   output      dp_sts_type              sts,
   input  wire logic                    req_command,
   input  wire logic [KEY_W-1:0]        req_key,
   input  wire logic [ROW_FIELD_W-1:0]  req_read_row,
   input  wire logic [SLOT_FIELD_W-1:0] req_read_slot,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   output      logic [STATUS_W-1:0]     rsp_status,
   output      logic [ROW_FIELD_W-1:0]  rsp_placed_row,
   output      logic [SLOT_FIELD_W-1:0] rsp_placed_slot,
   output      logic [KEY_W-1:0]        rsp_read_value
);

   localparam int ROW_W    = $clog2(ROW_COUNT);
   localparam int SLOT_W   = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
   localparam int ROW_BITS = SLOTS_PER_ROW * KEY_W;
   localparam int PAD_W    = HASH_STEPS * HASH_DIGIT_W;
   localparam logic [ROW_W:0]   ROW_LIM  = (ROW_W + 1)'(ROW_COUNT);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROW_COUNT - 1);

   logic [ROW_W-1:0]        clr_row_ff;
   logic [ROW_W-1:0]        clr_row_in;
   logic [KEY_W-1:0]        key_ff;
   logic [PAD_W-1:0]        key_sh_ff;
   logic [PAD_W-1:0]        key_sh_in;
   logic [ROW_FIELD_W-1:0]  rrow_ff;
   logic [SLOT_FIELD_W-1:0] rslot_ff;
   logic [ROW_W-1:0]        rem_ff;
   logic [ROW_W-1:0]        rem_in;
   logic [HASH_CNT_W-1:0]   hash_cnt_ff;
   logic [HASH_CNT_W-1:0]   hash_cnt_in;
   logic [ROW_W-1:0]        probe_row_ff;
   logic [ROW_W-1:0]        probe_row_in;
   logic [ROW_W-1:0]        tried_ff;
   logic [ROW_W-1:0]        tried_in;

   status_type              pend_status_ff;
   status_type              pend_status_in;
   logic [ROW_FIELD_W-1:0]  pend_row_ff;
   logic [ROW_FIELD_W-1:0]  pend_row_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff;
   logic [SLOT_FIELD_W-1:0] pend_slot_in;
   logic [KEY_W-1:0]        pend_value_ff;
   logic [KEY_W-1:0]        pend_value_in;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   status_type              out_status_ff;
   logic [ROW_FIELD_W-1:0]  out_row_ff;
   logic [SLOT_FIELD_W-1:0] out_slot_ff;
   logic [KEY_W-1:0]        out_value_ff;

   logic                    ram_wr_en;
   logic [ROW_W-1:0]        ram_wr_addr;
   logic [ROW_BITS-1:0]     ram_wr_data;
   logic                    ram_rd_en;
   logic [ROW_W-1:0]        ram_rd_addr;
   logic [ROW_BITS-1:0]     ram_rd_data;

   logic                    found;
   logic [SLOT_W-1:0]       found_slot;
   logic [ROW_BITS-1:0]     merged_row;
   logic [KEY_W-1:0]        read_word;
   logic                    read_in_range;

   bhi_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROW_COUNT),
      .AW    (ROW_W)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // radix-16 remainder by ROW_COUNT, most significant digit first
   always_comb begin
      logic [ROW_W:0]          r;
      logic [HASH_DIGIT_W-1:0] digit;
      digit = key_sh_ff[PAD_W-1 -: HASH_DIGIT_W];
      r     = {1'b0, rem_ff};
      for (int i = HASH_DIGIT_W - 1; i >= 0; i--) begin
         r = {r[ROW_W-1:0], digit[i]};
         if (r >= ROW_LIM) begin
            r = r - ROW_LIM;
         end
      end
      rem_in = r[ROW_W-1:0];
   end

   // lowest empty slot of the probed row, and the row with the key merged in
   always_comb begin
      found      = 1'b0;
      found_slot = '0;
      for (int s = SLOTS_PER_ROW - 1; s >= 0; s--) begin
         if (ram_rd_data[s*KEY_W +: KEY_W] == '0) begin
            found      = 1'b1;
            found_slot = SLOT_W'(s);
         end
      end
      merged_row = ram_rd_data;
      for (int s = 0; s < SLOTS_PER_ROW; s++) begin
         if (32'(found_slot) == s) begin
            merged_row[s*KEY_W +: KEY_W] = key_ff;
         end
      end
   end

   always_comb begin
      read_in_range = (32'(rrow_ff) < ROW_COUNT) && (32'(rslot_ff) < SLOTS_PER_ROW);
      read_word     = '0;
      for (int s = 0; s < SLOTS_PER_ROW; s++) begin
         if (32'(rslot_ff) == s) begin
            read_word = ram_rd_data[s*KEY_W +: KEY_W];
         end
      end
      if (!read_in_range) begin
         read_word = '0;
      end
   end

   always_comb begin
      ram_wr_en   = cmd.clear_step || cmd.probe_write;
      ram_wr_addr = cmd.clear_step ? clr_row_ff : probe_row_ff;
      ram_wr_data = cmd.clear_step ? '0 : merged_row;
      ram_rd_en   = cmd.probe_rd || cmd.read_rd;
      ram_rd_addr = cmd.probe_rd ? probe_row_ff : ROW_W'(rrow_ff);
   end

   always_comb begin
      clr_row_in   = cmd.clear_step ? clr_row_ff + 1'b1 : clr_row_ff;
      key_sh_in    = key_sh_ff;
      hash_cnt_in  = hash_cnt_ff;
      probe_row_in = probe_row_ff;
      tried_in     = tried_ff;
      if (cmd.capture) begin
         key_sh_in   = PAD_W'(req_key);
         hash_cnt_in = '0;
      end else if (cmd.hash_step) begin
         key_sh_in   = key_sh_ff << HASH_DIGIT_W;
         hash_cnt_in = hash_cnt_ff + 1'b1;
      end
      if (cmd.probe_start) begin
         probe_row_in = rem_in;
         tried_in     = '0;
      end else if (cmd.probe_next) begin
         probe_row_in = (probe_row_ff == ROW_LAST) ? '0 : probe_row_ff + 1'b1;
         tried_in     = tried_ff + 1'b1;
      end
   end

   always_comb begin
      pend_status_in = pend_status_ff;
      pend_row_in    = pend_row_ff;
      pend_slot_in   = pend_slot_ff;
      pend_value_in  = pend_value_ff;
      if (cmd.set_zero) begin
         pend_status_in = STATUS_ZERO;
         pend_row_in    = '0;
         pend_slot_in   = '0;
         pend_value_in  = '0;
      end else if (cmd.set_full) begin
         pend_status_in = STATUS_FULL;
         pend_row_in    = '0;
         pend_slot_in   = '0;
         pend_value_in  = '0;
      end else if (cmd.probe_write) begin
         pend_status_in = STATUS_INSERTED;
         pend_row_in    = ROW_FIELD_W'(probe_row_ff);
         pend_slot_in   = SLOT_FIELD_W'(found_slot);
         pend_value_in  = '0;
      end else if (cmd.read_cap) begin
         pend_status_in = STATUS_READ;
         pend_row_in    = '0;
         pend_slot_in   = '0;
         pend_value_in  = read_word;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_row_ff   <= clr_row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff   <= req_key;
         rrow_ff  <= req_read_row;
         rslot_ff <= req_read_slot;
         rem_ff   <= '0;
      end else if (cmd.hash_step) begin
         rem_ff <= rem_in;
      end
      key_sh_ff      <= key_sh_in;
      hash_cnt_ff    <= hash_cnt_in;
      probe_row_ff   <= probe_row_in;
      tried_ff       <= tried_in;
      pend_status_ff <= pend_status_in;
      pend_row_ff    <= pend_row_in;
      pend_slot_ff   <= pend_slot_in;
      pend_value_ff  <= pend_value_in;
      if (cmd.load_out) begin
         out_status_ff <= pend_status_ff;
         out_row_ff    <= pend_row_ff;
         out_slot_ff   <= pend_slot_ff;
         out_value_ff  <= pend_value_ff;
      end
   end

   always_comb begin
      sts            = '0;
      sts.clear_last = (clr_row_ff == ROW_LAST);
      sts.in_read    = (req_command == CMD_READ);
      sts.in_zero    = (req_key == '0);
      sts.hash_last  = (hash_cnt_ff == HASH_CNT_W'(HASH_STEPS - 1));
      sts.found      = found;
      sts.probe_last = (tried_ff == ROW_LAST);
      sts.out_free   = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_placed_row  = out_row_ff;
   assign rsp_placed_slot = out_slot_ff;
   assign rsp_read_value  = out_value_ff;

endmodule

`default_nettype wire

/* hw/rtl/bucket_hash_insert.sv */
// Top level of the bucket hash insert block: hash table of ROW_COUNT rows by
// SLOTS_PER_ROW slots with linear probing. Depends on bhi_pkg, bhi_req_if,
// bhi_rsp_if, bhi_ctrl, bhi_dp and bucket_hash_insert_defines.svh.
//
//   channel    direction  handshake    payload
//   req_chan   in         valid/ready  command, key, read_row, read_slot
//   rsp_chan   out        valid/ready  status, placed_row, placed_slot, read_value
//
// One transaction at a time. Read: a RAM read state, then a capture state.
// Insert of a zero key: straight to the result. Insert: the hash unit takes
// the key one 4-bit digit at a time, most significant first, and each probed
// row costs a RAM read state and a check state.
// After reset a clearing pass writes zero to every row, with req_chan.ready
// low. A result waits in the output register; the next transaction is taken
// while it waits and holds only at its own end.
`default_nettype none
`include "bucket_hash_insert_defines.svh"

module bucket_hash_insert
   import bhi_pkg::*;
#(
   parameter int ROW_COUNT     = DEF_ROW_COUNT,
   parameter int SLOTS_PER_ROW = DEF_SLOTS_PER_ROW
) (
   input wire logic  clock,
   input wire logic  reset,
   bhi_req_if.sink   req_chan,
   bhi_rsp_if.source rsp_chan
);

   ctrl_cmd_type cmd;
   dp_sts_type   sts;
   logic         req_ready;

   bhi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bhi_dp #(
      .ROW_COUNT     (ROW_COUNT),
      .SLOTS_PER_ROW (SLOTS_PER_ROW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_command     (req_chan.command),
      .req_key         (req_chan.key),
      .req_read_row    (req_chan.read_row),
      .req_read_slot   (req_chan.read_slot),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_placed_row  (rsp_chan.placed_row),
      .rsp_placed_slot (rsp_chan.placed_slot),
      .rsp_read_value  (rsp_chan.read_value)
   );

   assign req_chan.ready = req_ready;

   `BHI_ASSERT_NOW(a_no_accept_in_clear, clock, reset, cmd.clear_step, !req_chan.ready, "request taken during clearing pass")
   `BHI_ASSERT_NOW(a_load_when_free, clock, reset, cmd.load_out, sts.out_free, "result loaded over a waiting result")
   `BHI_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "second request taken while busy")
   `BHI_ASSERT_NOW(a_write_on_hit, clock, reset, cmd.probe_write, sts.found && !cmd.set_full, "row written without an empty slot")

endmodule

`default_nettype wire
